// ===== hdl/cpoe_pkg.sv =====
// Shared constants and types for the collider pair overlap event block.
// No dependencies; imported by every module under hdl.
package cpoe_pkg;

  localparam int MAX_SLOTS_DEF  = 32;
  localparam int COORD_BITS_DEF = 16;

  // Slot field and result queue sizing
  localparam int SLOT_W     = 5;
  localparam int HIT_CAP    = 31;
  localparam int CNT_W      = $clog2(HIT_CAP + 1);
  localparam int OUT_DATA_W = 8;

  // Flag bits at the bottom of a table row
  localparam int FLAG_W       = 4;
  localparam int FLAG_PRESENT = 0;
  localparam int FLAG_ENABLED = 1;
  localparam int FLAG_ACTION  = 2;
  localparam int FLAG_SPHERE  = 3;

  // Input selector
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              q_sphere;
    logic              o_sphere;
    logic [SLOT_W-1:0] slot;
  } pair_in_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } pair_out_t;

endpackage

// ===== hdl/collider_pair_overlap_events.sv =====
// Collider pair overlap events, top level. A write gets one beat, loaded in S_FIN into
// the output register. A query of a present, enabled slot holds the block while the table
// read port walks one slot per cycle into the 4-stage pair tester, which then drains, plus
// any m_tready stall (an absent or disabled slot goes straight to the final beat); hits
// stream out during the walk and drain. Reset (rst, sync, active high) starts a clearing
// pass over every slot, s_tready low. Depends on cpoe_pkg, cpoe_table, cpoe_pair_unit.
module collider_pair_overlap_events
  import cpoe_pkg::*;
#(
  parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // s_tdata, low bit up: slot, present, enabled, has_action, shape,
  //   center_x, center_y, center_z, half_x, half_y, half_z, zero pad
  input  logic                                            s_tvalid,
  output logic                                            s_tready,
  input  logic [((SLOT_W + FLAG_W + 6*COORD_BITS - 3 + 7) / 8) * 8 - 1:0] s_tdata,
  // s_tuser: mode
  input  logic                                            s_tuser,
  output logic                                            m_tvalid,
  input  logic                                            m_tready,
  // m_tdata, low bit up: other_slot, zero pad
  output logic [OUT_DATA_W-1:0]                           m_tdata,
  // m_tuser: found
  output logic                                            m_tuser,
  output logic                                            m_tlast
);

  localparam int CW     = COORD_BITS;
  localparam int HW     = CW - 1;
  localparam int ROW_W  = FLAG_W + 3*CW + 3*HW;
  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int CTR_OFS = FLAG_W;
  localparam int HLF_OFS = FLAG_W + 3*CW;
  localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(MAX_SLOTS - 1);

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,  // clearing pass after reset
    S_IDLE  = 6'b000010,
    S_QLD   = 6'b000100,  // queried row arrives
    S_WALK  = 6'b001000,  // one table read per cycle
    S_DRAIN = 6'b010000,  // pair tester empties
    S_FIN   = 6'b100000   // final beat of the item
  } state_t;

  state_t state, state_next;

  // input beat fields
  logic [SLOT_W-1:0] in_slot;
  logic [ROW_W-1:0]  in_row;
  logic [31:0]       slot_ext;
  logic              slot_ok;
  logic [ADDR_W-1:0] slot_addr;
  logic              accept;

  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_row    = s_tdata[SLOT_W +: ROW_W];
  assign slot_ext  = 32'(in_slot);
  assign slot_ok   = slot_ext < 32'(MAX_SLOTS);
  assign slot_addr = slot_ext[ADDR_W-1:0];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // walk / clear counter and query context
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] q_addr;
  logic              q_ok;
  logic [ROW_W-1:0]  q_row;

  // table ports
  logic              tb_we;
  logic [ADDR_W-1:0] tb_waddr;
  logic [ROW_W-1:0]  tb_wdata;
  logic [ADDR_W-1:0] tb_raddr;
  logic [ROW_W-1:0]  rd_data;

  always_comb begin
    if (state == S_CLR) begin
      tb_we    = 1'b1;
      tb_waddr = idx;
      tb_wdata = '0;
    end else begin
      tb_we    = accept && (s_tuser == MODE_WRITE) && slot_ok;
      tb_waddr = slot_addr;
      // a clearing write (present flag low) zeroes the whole row
      tb_wdata = in_row[FLAG_PRESENT] ? in_row : '0;
    end
    tb_raddr = (state == S_WALK) ? idx : slot_addr;
  end

  cpoe_table #(
    .MAX_SLOTS (MAX_SLOTS),
    .ROW_W     (ROW_W),
    .ADDR_W    (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (rd_data)
  );

  // read stage: the row of the walked slot is in rd_data
  logic              r_valid;
  logic [ADDR_W-1:0] r_idx;
  logic [31:0]       r_ext;
  logic              cand;
  pair_in_t          pu_in;
  pair_out_t         pu_res;
  logic              pu_busy;

  logic signed [CW-1:0] qc [3];
  logic        [HW-1:0] qh [3];
  logic signed [CW-1:0] oc [3];
  logic        [HW-1:0] oh [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k] = q_row[CTR_OFS + k*CW +: CW];
      qh[k] = q_row[HLF_OFS + k*HW +: HW];
      oc[k] = rd_data[CTR_OFS + k*CW +: CW];
      oh[k] = rd_data[HLF_OFS + k*HW +: HW];
    end
  end

  assign r_ext = 32'(r_idx);
  // self pair skipped; events need an action flag on either side
  assign cand  = r_valid && rd_data[FLAG_PRESENT] && (r_idx != q_addr) &&
                 (q_row[FLAG_ACTION] || rd_data[FLAG_ACTION]);

  assign pu_in.valid    = cand;
  assign pu_in.q_sphere = q_row[FLAG_SPHERE];
  assign pu_in.o_sphere = rd_data[FLAG_SPHERE];
  assign pu_in.slot     = r_ext[SLOT_W-1:0];

  cpoe_pair_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_pair (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pu_in),
    .qc   (qc),
    .qh   (qh),
    .oc   (oc),
    .oh   (oh),
    .res  (pu_res),
    .busy (pu_busy)
  );

  // hit queue: written by the tester, read by the output register
  logic [SLOT_W-1:0] hitq [HIT_CAP];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rd;
  logic [CNT_W:0]    rd1;
  logic [CNT_W:0]    cnt1;
  logic              hit_wr;

  assign rd1    = {1'b0, rd} + 1'b1;
  assign cnt1   = {1'b0, cnt};
  assign hit_wr = pu_res.valid && pu_res.hit && (cnt < CNT_W'(HIT_CAP));

  // output loading; the newest hit is held back until it is known whether it is the last
  logic              out_free;
  logic              ld;
  logic              ld_entry;
  logic              ld_found;
  logic [SLOT_W-1:0] ld_slot;
  logic              ld_last;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    ld       = 1'b0;
    ld_entry = 1'b0;
    ld_found = 1'b0;
    ld_slot  = '0;
    ld_last  = 1'b0;
    if (out_free) begin
      if (state == S_FIN) begin
        ld      = 1'b1;
        ld_last = (cnt == '0) || (rd1 == cnt1);
        if (cnt != '0) begin
          ld_entry = 1'b1;
          ld_found = 1'b1;
          ld_slot  = hitq[rd];
        end
      end else if ((state == S_WALK || state == S_DRAIN) && (rd1 < cnt1)) begin
        ld       = 1'b1;
        ld_entry = 1'b1;
        ld_found = 1'b1;
        ld_slot  = hitq[rd];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (idx == IDX_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = (s_tuser == MODE_QUERY) ? S_QLD : S_FIN;
      end
      S_QLD: begin
        // absent, disabled or out-of-range query slot: no hits
        if (q_ok && rd_data[FLAG_PRESENT] && rd_data[FLAG_ENABLED]) begin
          state_next = S_WALK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_WALK: begin
        if (idx == IDX_LAST) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!r_valid && !pu_busy) state_next = S_FIN;
      end
      S_FIN: begin
        if (ld && ld_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      idx      <= '0;
      r_valid  <= 1'b0;
      cnt      <= '0;
      rd       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      r_valid <= (state == S_WALK);

      if (state == S_CLR || state == S_WALK) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      end

      if (accept) begin
        cnt <= '0;
        rd  <= '0;
      end else begin
        if (hit_wr) cnt <= cnt + 1'b1;
        if (ld_entry) rd <= rd + 1'b1;
      end

      if (ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end

    r_idx <= idx;
    if (accept) begin
      q_addr <= slot_addr;
      q_ok   <= slot_ok;
    end
    if (state == S_QLD) q_row <= rd_data;
    if (hit_wr) hitq[cnt] <= pu_res.slot;
    if (ld) begin
      m_tuser <= ld_found;
      m_tdata <= OUT_DATA_W'(ld_slot);
      m_tlast <= ld_last;
    end
  end

  // ---------------------------------------------------------------------------
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("beat without a hit is not marked last");

  a_hit_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(HIT_CAP))
    else $error("hit count above cap");

  a_rd_behind: assert property (@(posedge clk) disable iff (rst)
    rd <= cnt)
    else $error("hit queue read passed write");

  a_tester_window: assert property (@(posedge clk) disable iff (rst)
    pu_res.valid |-> (state == S_WALK || state == S_DRAIN))
    else $error("pair result outside a walk");

endmodule

// ===== hdl/cpoe_table.sv =====
// Collider table: one write port, one registered read port.
// Depends on cpoe_pkg.
module cpoe_table
  import cpoe_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int ROW_W     = 97,
  parameter int ADDR_W    = $clog2(MAX_SLOTS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ROW_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ROW_W-1:0]  rdata
);

  logic [ROW_W-1:0] mem [MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cpoe_pair_unit.sv =====
// Four-stage pair overlap tester: box-box, sphere-sphere and box-sphere.
// Takes one candidate pair per cycle. Depends on cpoe_pkg.
module cpoe_pair_unit
  import cpoe_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pair_in_t                     ctl,
  input  logic signed [COORD_BITS-1:0] qc [3],
  input  logic        [COORD_BITS-2:0] qh [3],
  input  logic signed [COORD_BITS-1:0] oc [3],
  input  logic        [COORD_BITS-2:0] oh [3],
  output pair_out_t                    res,
  output logic                         busy
);

  localparam int CW   = COORD_BITS;
  localparam int HW   = CW - 1;
  localparam int MW   = CW + 1;
  localparam int SQW  = 2 * MW;
  localparam int SUMW = SQW + 2;
  localparam int RW   = CW;
  localparam int RSQW = 2 * RW;

  // stage A: centre distance per axis
  logic signed [MW-1:0] e      [3];
  logic        [MW-1:0] ae_c   [3];
  logic        [HW-1:0] sub_c  [3];
  logic        [RW-1:0] hsum_c [3];
  logic        [RW-1:0] r_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e[k]      = {qc[k][CW-1], qc[k]} - {oc[k][CW-1], oc[k]};
      ae_c[k]   = e[k][MW-1] ? (~e[k] + 1'b1) : e[k];
      hsum_c[k] = {1'b0, qh[k]} + {1'b0, oh[k]};
      if (ctl.q_sphere && !ctl.o_sphere) begin
        sub_c[k] = oh[k];
      end else if (!ctl.q_sphere && ctl.o_sphere) begin
        sub_c[k] = qh[k];
      end else begin
        sub_c[k] = '0;
      end
    end
    if (ctl.q_sphere && ctl.o_sphere) begin
      r_c = {1'b0, qh[0]} + {1'b0, oh[0]};
    end else if (ctl.q_sphere) begin
      r_c = {1'b0, qh[0]};
    end else if (ctl.o_sphere) begin
      r_c = {1'b0, oh[0]};
    end else begin
      r_c = '0;
    end
  end

  logic              a_v, b_v, c_v;
  logic [SLOT_W-1:0] a_slot, b_slot, c_slot;
  logic              a_bb, b_bb, c_bb;
  logic [MW-1:0]     a_ae   [3];
  logic [HW-1:0]     a_sub  [3];
  logic [RW-1:0]     a_hsum [3];
  logic [RW-1:0]     a_r, b_r;

  // stage B: distance past the box face, box-box axis checks
  logic [MW-1:0]     b_mag  [3];
  logic [2:0]        b_ok;

  // stage C: squares
  logic [SQW-1:0]    c_sq   [3];
  logic [RSQW-1:0]   c_rsq;
  logic              c_all;

  logic [SUMW-1:0]   dsq;

  always_comb begin
    dsq = {2'b00, c_sq[0]} + {2'b00, c_sq[1]} + {2'b00, c_sq[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      a_v       <= ctl.valid;
      b_v       <= a_v;
      c_v       <= b_v;
      res.valid <= c_v;
    end

    a_slot <= ctl.slot;
    a_bb   <= !ctl.q_sphere && !ctl.o_sphere;
    a_r    <= r_c;
    for (int k = 0; k < 3; k++) begin
      a_ae[k]   <= ae_c[k];
      a_sub[k]  <= sub_c[k];
      a_hsum[k] <= hsum_c[k];
    end

    b_slot <= a_slot;
    b_bb   <= a_bb;
    b_r    <= a_r;
    for (int k = 0; k < 3; k++) begin
      b_mag[k] <= (a_ae[k] > {2'b00, a_sub[k]}) ? (a_ae[k] - {2'b00, a_sub[k]}) : '0;
      b_ok[k]  <= a_ae[k] <= {1'b0, a_hsum[k]};
    end

    c_slot <= b_slot;
    c_bb   <= b_bb;
    c_all  <= &b_ok;
    c_rsq  <= {{RW{1'b0}}, b_r} * {{RW{1'b0}}, b_r};
    for (int k = 0; k < 3; k++) begin
      c_sq[k] <= {{MW{1'b0}}, b_mag[k]} * {{MW{1'b0}}, b_mag[k]};
    end

    res.slot <= c_slot;
    res.hit  <= c_bb ? c_all : (dsq <= {{(SUMW - RSQW){1'b0}}, c_rsq});
  end

  assign busy = a_v || b_v || c_v || res.valid;

endmodule
